FILE: sv/wspd_pkg.sv
// shared types, register codes and a saturation helper for the wheel speed controller
package wspd_pkg;

   localparam int unsigned CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_GAIN        = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_GAIN        = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PER_TICK = 4'd7;

   localparam logic CMD_SPEED = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // drive limit is PWM_LIMIT in Q16.16
   localparam logic signed [63:0] PWM_LIMIT_Q    = 64'sd255 <<< 16;
   localparam logic signed [63:0] INTEGRAL_LIMIT = 64'sd16777216;
   localparam logic signed [31:0] STOP_BAND      = 32'sd655;

   localparam int unsigned MUL_A_W = 50;
   localparam int unsigned MUL_B_W = 33;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W - 1;
   localparam int unsigned DIV_W   = 50;
   localparam int unsigned DIV_D_W = 16;

   typedef struct packed {
      logic               command;
      logic signed [15:0] x_request;
      logic signed [15:0] y_request;
      logic signed [15:0] turn_request;
      logic [31:0]        encoder_position;
      logic [15:0]        elapsed_ms;
   } wspd_req_type;

   typedef struct packed {
      logic [7:0]         duty;
      logic               forward;
      logic               backward;
      logic signed [31:0] distance;
      logic               is_stopped;
   } wspd_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7fff_ffff) begin
         r = 32'sh7fff_ffff;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/wspd_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
module wspd_mul import wspd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [MUL_A_W-1:0]  a,
   input  logic signed [MUL_B_W-1:0]  b,
   output logic                       done,
   output logic signed [MUL_P_W-1:0]  product
);

   localparam int unsigned STEPS = MUL_B_W - 1;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic signed [MUL_A_W:0]   hi_ff, hi_in, sum;
   logic [STEPS-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic [MUL_B_W-1:0]        b_neg;

   always_comb begin
      b_neg   = -b;
      sum     = lo_ff[0] ? hi_ff + {a_ff[MUL_A_W-1], a_ff} : hi_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // negative multiplier: negate both sides
         a_in    = b[MUL_B_W-1] ? -a : a;
         lo_in   = b[MUL_B_W-1] ? b_neg[STEPS-1:0] : b[STEPS-1:0];
         hi_in   = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[STEPS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff[MUL_A_W-1:0], lo_ff};

endmodule

FILE: sv/wspd_div.sv
// bit-serial restoring divider, signed dividend, truncates toward zero
module wspd_div import wspd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIV_W-1:0]  num,
   input  logic [DIV_D_W-1:0]       den,
   output logic                     done,
   output logic signed [DIV_W-1:0]  quotient
);

   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]   q_ff, q_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_D_W:0]   trial;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = {rem_ff, q_ff[DIV_W-1]};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = num[DIV_W-1];
         q_in    = num[DIV_W-1] ? -num : num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_D_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_D_W-1:0];
            q_in   = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

FILE: sv/wheel_speed_pid_drive_core.sv
// wheel speed controller top level: registers, sequencer and shared arithmetic units
//
// One wheel's PID speed controller in Q16.16. A speed request (command 0) mixes x, y and
// turn demands into the target speed and gives no result (it is ignored when disabled); a
// tick (command 1) gives one result: a brake when disabled or stopped, a drive otherwise.
// The work runs on two shared bit-serial units: a multiplier that takes one multiplier
// bit a cycle and a restoring divider that takes one quotient bit a cycle, used one after
// the other by the sequencer. One item is worked on at a time; a finished result waits in
// the output register while the next request is taken.
module wheel_speed_pid_drive_core import wspd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wspd_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wspd_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MIX_X, ST_MIX_Y, ST_MIX_T, ST_DIST, ST_SPEED, ST_EMS,
      ST_IDIV, ST_DDIV, ST_PTERM, ST_ITERM, ST_DTERM, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic               enable_ff, enable_in;
   logic [31:0]        kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, dpt_ff, dpt_in;
   logic signed [31:0] xg_ff, xg_in, yg_ff, yg_in, tg_ff, tg_in;

   logic signed [31:0] target_ff, target_in, isum_ff, isum_in, perr_ff, perr_in;
   logic [31:0]        ppos_ff, ppos_in;
   logic               stopped_ff, stopped_in;

   wspd_req_type       in_ff, in_in;
   logic [15:0]        ms_ff, ms_in;
   logic signed [49:0] acc_ff, acc_in, tmp_ff, tmp_in, integ_ff, integ_in;
   logic signed [49:0] deriv_ff, deriv_in;
   logic signed [31:0] dist_ff, dist_in, err_ff, err_in;
   logic signed [63:0] drive_ff, drive_in;
   wspd_rsp_type       res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               wait_ff, wait_in;

   logic                      mul_start, mul_done;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      div_start, div_done;
   logic signed [DIV_W-1:0]   div_num, div_q;
   logic [DIV_D_W-1:0]        div_den;

   function automatic logic signed [49:0] times1000(input logic signed [49:0] v);
      return (v <<< 10) - (v <<< 5) + (v <<< 3);
   endfunction

   wspd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   wspd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // operand selection for the shared units
   always_comb begin
      logic [31:0]        dx;
      logic signed [32:0] ediff;
      dx        = in_ff.encoder_position - ppos_ff;
      ediff     = {err_ff[31], err_ff} - {perr_ff[31], perr_ff};
      mul_a     = '0;
      mul_b     = '0;
      mul_start = 1'b0;
      div_num   = '0;
      div_den   = ms_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_MIX_X: begin
            mul_a = MUL_A_W'(in_ff.x_request);
            mul_b = MUL_B_W'(xg_ff);
            mul_start = !wait_ff;
         end
         ST_MIX_Y: begin
            mul_a = MUL_A_W'(in_ff.y_request);
            mul_b = MUL_B_W'(yg_ff);
            mul_start = !wait_ff;
         end
         ST_MIX_T: begin
            mul_a = MUL_A_W'(in_ff.turn_request);
            mul_b = MUL_B_W'(tg_ff);
            mul_start = !wait_ff;
         end
         ST_DIST: begin
            mul_a = MUL_A_W'($signed(dx));
            mul_b = {1'b0, dpt_ff};
            mul_start = !wait_ff;
         end
         ST_SPEED: begin
            div_num = times1000(50'(dist_ff));
            div_start = !wait_ff;
         end
         ST_EMS: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = {17'd0, ms_ff};
            mul_start = !wait_ff;
         end
         ST_IDIV: begin
            div_num = tmp_ff;
            div_den = 16'd1000;
            div_start = !wait_ff;
         end
         ST_DDIV: begin
            div_num = times1000(50'(ediff));
            div_start = !wait_ff;
         end
         ST_PTERM: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = {1'b0, kp_ff};
            mul_start = !wait_ff;
         end
         ST_ITERM: begin
            mul_a = integ_ff;
            mul_b = {1'b0, ki_ff};
            mul_start = !wait_ff;
         end
         ST_DTERM: begin
            mul_a = deriv_ff;
            mul_b = {1'b0, kd_ff};
            mul_start = !wait_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic signed [49:0] mix;
      logic signed [31:0] spd, dist_v, speed_v;
      logic signed [63:0] drv, mag, integ64;
      state_in     = state_ff;
      enable_in    = enable_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      dpt_in       = dpt_ff;
      xg_in        = xg_ff;
      yg_in        = yg_ff;
      tg_in        = tg_ff;
      target_in    = target_ff;
      isum_in      = isum_ff;
      perr_in      = perr_ff;
      ppos_in      = ppos_ff;
      stopped_in   = stopped_ff;
      in_in        = in_ff;
      ms_in        = ms_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      dist_in      = dist_ff;
      err_in       = err_ff;
      drive_in     = drive_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wait_in      = (mul_start || div_start) ? 1'b1 :
                     (mul_done || div_done) ? 1'b0 : wait_ff;
      mix          = acc_ff + mul_p[49:0];
      spd          = sat32(64'(mix >>> 15));
      dist_v       = sat32(64'($signed(mul_p[63:12])));
      speed_v      = sat32(64'(div_q));
      drv          = drive_ff - mul_p[79:16];
      mag          = '0;
      integ64      = 64'(integ_ff);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:        enable_in = csr_data[0];
            CSR_PROP_GAIN:     kp_in     = csr_data;
            CSR_INTEGRAL_GAIN: ki_in     = csr_data;
            CSR_DERIV_GAIN:    kd_in     = csr_data;
            CSR_X_GAIN:        xg_in     = csr_data;
            CSR_Y_GAIN:        yg_in     = csr_data;
            CSR_TURN_GAIN:     tg_in     = csr_data;
            CSR_DIST_PER_TICK: dpt_in    = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in = req_data;
               ms_in = (req_data.elapsed_ms == 16'd0) ? 16'd1 : req_data.elapsed_ms;
               if (req_data.command == CMD_SPEED) begin
                  if (enable_ff) state_in = ST_MIX_X;
               end else if (!enable_ff) begin
                  res_in   = '{duty: 8'hff, forward: 1'b1, backward: 1'b1,
                               distance: 32'sd0, is_stopped: 1'b1};
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIST;
               end
            end
         end
         ST_MIX_X: if (mul_done) begin
            acc_in   = mul_p[49:0];
            state_in = ST_MIX_Y;
         end
         ST_MIX_Y: if (mul_done) begin
            acc_in   = mix;
            state_in = ST_MIX_T;
         end
         ST_MIX_T: if (mul_done) begin
            // a sign change or a stop clears the pid terms
            if ((target_ff > 0) != (spd > 0)) begin
               isum_in = '0;
               perr_in = '0;
            end
            if (spd >= -STOP_BAND && spd <= STOP_BAND) begin
               isum_in    = '0;
               perr_in    = '0;
               target_in  = '0;
               stopped_in = 1'b1;
            end else begin
               stopped_in = 1'b0;
               target_in  = spd;
            end
            state_in = ST_IDLE;
         end
         ST_DIST: if (mul_done) begin
            dist_in = dist_v;
            ppos_in = in_ff.encoder_position;
            if (stopped_ff) begin
               res_in   = '{duty: 8'hff, forward: 1'b1, backward: 1'b1,
                            distance: dist_v, is_stopped: 1'b1};
               state_in = ST_OUT;
            end else begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: if (div_done) begin
            err_in   = sat32(64'(target_ff) - 64'(speed_v));
            state_in = ST_EMS;
         end
         ST_EMS: if (mul_done) begin
            tmp_in   = mul_p[49:0];
            state_in = ST_IDIV;
         end
         ST_IDIV: if (div_done) begin
            integ_in = 50'(isum_ff) + div_q;
            state_in = ST_DDIV;
         end
         ST_DDIV: if (div_done) begin
            deriv_in = div_q;
            state_in = ST_PTERM;
         end
         ST_PTERM: if (mul_done) begin
            drive_in = mul_p[79:16];
            state_in = ST_ITERM;
         end
         ST_ITERM: if (mul_done) begin
            drive_in = drive_ff + mul_p[79:16];
            state_in = ST_DTERM;
         end
         ST_DTERM: if (mul_done) begin
            if (drv > PWM_LIMIT_Q) drv = PWM_LIMIT_Q;
            else if (drv < -PWM_LIMIT_Q) drv = -PWM_LIMIT_Q;
            mag = (drv > 0) ? drv : -drv;
            if (integ64 > INTEGRAL_LIMIT) isum_in = 32'(INTEGRAL_LIMIT);
            else if (integ64 < -INTEGRAL_LIMIT) isum_in = 32'(-INTEGRAL_LIMIT);
            else isum_in = integ_ff[31:0];
            perr_in  = err_ff;
            res_in   = '{duty: mag[23:16], forward: drv > 0, backward: !(drv > 0),
                         distance: dist_ff, is_stopped: 1'b0};
            state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_valid_ff || rsp_ready) begin
            rsp_data_in  = res_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         dpt_ff       <= '0;
         xg_ff        <= '0;
         yg_ff        <= '0;
         tg_ff        <= '0;
         target_ff    <= '0;
         isum_ff      <= '0;
         perr_ff      <= '0;
         ppos_ff      <= '0;
         stopped_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         dpt_ff       <= dpt_in;
         xg_ff        <= xg_in;
         yg_ff        <= yg_in;
         tg_ff        <= tg_in;
         target_ff    <= target_in;
         isum_ff      <= isum_in;
         perr_ff      <= perr_in;
         ppos_ff      <= ppos_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_ff      <= wait_in;
      end
      in_ff       <= in_in;
      ms_ff       <= ms_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      integ_ff    <= integ_in;
      deriv_ff    <= deriv_in;
      dist_ff     <= dist_in;
      err_ff      <= err_in;
      drive_ff    <= drive_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stop_brakes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_stopped |->
         rsp_data.forward && rsp_data.backward && rsp_data.duty == 8'hff)
      else $error("stopped result does not brake");

   a_run_one_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_stopped |-> rsp_data.forward != rsp_data.backward)
      else $error("running result drives both or no legs");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MIX_X || state_ff == ST_MIX_Y || state_ff == ST_MIX_T ||
                   state_ff == ST_DIST || state_ff == ST_EMS || state_ff == ST_PTERM ||
                   state_ff == ST_ITERM || state_ff == ST_DTERM)
      else $error("multiplier finished outside a multiply step");

   a_integral_bound: assert property (@(posedge clock) disable iff (reset)
      64'(isum_ff) <= INTEGRAL_LIMIT && 64'(isum_ff) >= -INTEGRAL_LIMIT)
      else $error("integral outside its limit");

endmodule

FILE: sim/wspd_checker.sv
// wheel speed controller checker: watches the channels, predicts each tick result and compares
`timescale 1ns / 1ps

module wspd_checker import wspd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  wspd_req_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wspd_rsp_type         rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output int                   fail_count,
   output int                   pending
);

   localparam logic signed [63:0] DRIVE_CAP = 64'sd255 * 64'sd65536;
   localparam logic signed [63:0] INTEG_CAP = 64'sd16777216;
   localparam logic signed [31:0] STOP_EDGE = 32'sd655;

   // controller copy
   logic               wheel_on;
   logic [31:0]        gain_p, gain_i, gain_d, metres_per_count;
   logic signed [31:0] mix_x, mix_y, mix_turn;
   logic signed [31:0] target_spd, integ_sum, last_err;
   logic [31:0]        last_pos;
   logic               halted;

   wspd_rsp_type tick_results[$];

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // a * unsigned gain, floored to Q16.16
   function automatic logic signed [127:0] gain_mul(input logic signed [63:0] a,
                                                    input logic [31:0] g);
      logic signed [127:0] wa;
      logic signed [127:0] wg;
      wa = a;
      wg = {96'b0, g};
      return (wa * wg) >>> 16;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic speed_request(input wspd_req_type r);
      logic signed [63:0] gx, gy, gt, rx, ry, rt, mix;
      logic signed [31:0] spd;
      gx = mix_x; gy = mix_y; gt = mix_turn;
      rx = r.x_request; ry = r.y_request; rt = r.turn_request;
      if (!wheel_on) return;
      mix = gx * rx + gy * ry + gt * rt;
      spd = clip32(mix >>> 15);
      if ((target_spd > 0) != (spd > 0)) begin
         integ_sum = 0;
         last_err = 0;
      end
      if (spd >= -STOP_EDGE && spd <= STOP_EDGE) begin
         integ_sum = 0;
         last_err = 0;
         target_spd = 0;
         halted = 1'b1;
      end else begin
         halted = 1'b0;
         target_spd = spd;
      end
   endtask

   task automatic control_tick(input wspd_req_type r, output wspd_rsp_type e);
      logic signed [31:0]  d32, step_dist, spd, err;
      logic signed [63:0]  dx, ms, per, dist64, spd64, err64, integ, deriv, tgt, prev, isum;
      logic signed [127:0] drv, mag;
      e = '0;
      if (!wheel_on) begin
         e.duty = 8'hff; e.forward = 1'b1; e.backward = 1'b1; e.is_stopped = 1'b1;
         return;
      end
      d32 = r.encoder_position - last_pos;
      dx = d32;
      ms = {48'b0, r.elapsed_ms};
      if (ms == 0) ms = 1;
      last_pos = r.encoder_position;
      per = {32'b0, metres_per_count};
      step_dist = clip32((dx * per) >>> 12);
      dist64 = step_dist;
      spd = clip32((dist64 * 64'sd1000) / ms);
      e.distance = step_dist;
      if (halted) begin
         e.duty = 8'hff; e.forward = 1'b1; e.backward = 1'b1; e.is_stopped = 1'b1;
         return;
      end
      tgt = target_spd;
      spd64 = spd;
      err = clip32(tgt - spd64);
      err64 = err;
      isum = integ_sum;
      prev = last_err;
      integ = isum + (err64 * ms) / 64'sd1000;
      deriv = ((err64 - prev) * 64'sd1000) / ms;
      drv = gain_mul(err64, gain_p) + gain_mul(integ, gain_i) - gain_mul(deriv, gain_d);
      if (integ > INTEG_CAP) integ = INTEG_CAP;
      if (integ < -INTEG_CAP) integ = -INTEG_CAP;
      integ_sum = integ[31:0];
      last_err = err;
      if (drv > DRIVE_CAP) drv = DRIVE_CAP;
      if (drv < -DRIVE_CAP) drv = -DRIVE_CAP;
      mag = (drv > 0) ? drv : -drv;
      e.duty = mag[23:16];
      e.forward = (drv > 0);
      e.backward = !(drv > 0);
      e.is_stopped = 1'b0;
   endtask

   always @(posedge clock) begin
      wspd_rsp_type want;
      if (reset) begin
         wheel_on <= 1'b0;
         gain_p = 0; gain_i = 0; gain_d = 0; metres_per_count = 0;
         mix_x = 0; mix_y = 0; mix_turn = 0;
         target_spd = 0; integ_sum = 0; last_err = 0; last_pos = 0;
         halted = 1'b1;
         tick_results.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:        wheel_on <= csr_data[0];
               CSR_PROP_GAIN:     gain_p = csr_data;
               CSR_INTEGRAL_GAIN: gain_i = csr_data;
               CSR_DERIV_GAIN:    gain_d = csr_data;
               CSR_X_GAIN:        mix_x = csr_data;
               CSR_Y_GAIN:        mix_y = csr_data;
               CSR_TURN_GAIN:     mix_turn = csr_data;
               CSR_DIST_PER_TICK: metres_per_count = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.command == CMD_SPEED) begin
               speed_request(req_data);
            end else begin
               control_tick(req_data, want);
               tick_results.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (tick_results.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               want = tick_results.pop_front();
               if (rsp_data.duty != want.duty) report("duty", rsp_data.duty, want.duty);
               if (rsp_data.forward != want.forward)
                  report("forward", rsp_data.forward, want.forward);
               if (rsp_data.backward != want.backward)
                  report("backward", rsp_data.backward, want.backward);
               if (rsp_data.distance != want.distance)
                  report("distance", rsp_data.distance, want.distance);
               if (rsp_data.is_stopped != want.is_stopped)
                  report("is_stopped", rsp_data.is_stopped, want.is_stopped);
            end
         end
         pending = tick_results.size();
      end
   end

endmodule

FILE: sim/tb_top.sv
// wheel speed controller testbench top: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import wspd_pkg::*;

   localparam longint             CYCLE_LIMIT = 4000000;
   localparam int                 SETTLE      = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 4'd12;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   wspd_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   wspd_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;
   int                   fail_count;
   int                   pending;
   longint               cycles = 0;
   bit                   quiet = 1'b0;
   int                   stall_left = 0;
   logic [31:0]          enc_pos = 0;

   wheel_speed_pid_drive_core u_top (.*);

   wspd_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
         rsp_ready <= 1'b0;
         stall_left = gap_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(input wspd_req_type item);
      repeat (gap_len()) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic speed(input logic [15:0] x, input logic [15:0] y, input logic [15:0] t);
      wspd_req_type r;
      r = '0;
      r.command = CMD_SPEED;
      r.x_request = x; r.y_request = y; r.turn_request = t;
      r.encoder_position = $urandom;
      r.elapsed_ms = 16'($urandom);
      send(r);
   endtask

   task automatic tick(input logic [31:0] pos, input logic [15:0] ms);
      wspd_req_type r;
      r.command = CMD_TICK;
      r.x_request = 16'($urandom);
      r.y_request = 16'($urandom);
      r.turn_request = 16'($urandom);
      r.encoder_position = pos;
      r.elapsed_ms = ms;
      send(r);
   endtask

   function automatic logic [15:0] demand();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 1400) - 700);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_items(input int n);
      logic [15:0] ms;
      int          k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 14) begin
            speed(demand(), demand(), demand());
         end else begin
            if (k < 19) enc_pos = $urandom;
            else enc_pos = enc_pos + $urandom_range(0, 400) - 200;
            k = $urandom_range(0, 99);
            if (k < 80) ms = 16'($urandom_range(1, 20));
            else if (k < 88) ms = 16'd0;
            else ms = 16'($urandom);
            tick(enc_pos, ms);
         end
      end
   endtask

   task automatic setup(input int p);
      logic [31:0] mx;
      case (p)
         6: begin
            csr_write(CSR_PROP_GAIN, 32'hffff_ffff);
            csr_write(CSR_INTEGRAL_GAIN, 32'hffff_ffff);
            csr_write(CSR_DERIV_GAIN, 32'hffff_ffff);
            csr_write(CSR_X_GAIN, 32'h7fff_ffff);
            csr_write(CSR_Y_GAIN, 32'h8000_0000);
            csr_write(CSR_TURN_GAIN, 32'h7fff_ffff);
            csr_write(CSR_DIST_PER_TICK, 32'hffff_ffff);
         end
         7: begin
            csr_write(CSR_PROP_GAIN, 32'h0);
            csr_write(CSR_INTEGRAL_GAIN, 32'h0);
            csr_write(CSR_DERIV_GAIN, 32'h0);
            csr_write(CSR_X_GAIN, 32'h8000_0000);
            csr_write(CSR_Y_GAIN, 32'h0);
            csr_write(CSR_TURN_GAIN, 32'h0);
            csr_write(CSR_DIST_PER_TICK, 32'h0);
         end
         5: begin
            csr_write(CSR_PROP_GAIN, $urandom);
            csr_write(CSR_INTEGRAL_GAIN, $urandom);
            csr_write(CSR_DERIV_GAIN, $urandom);
            csr_write(CSR_X_GAIN, $urandom);
            csr_write(CSR_Y_GAIN, $urandom);
            csr_write(CSR_TURN_GAIN, $urandom);
            csr_write(CSR_DIST_PER_TICK, $urandom);
         end
         default: begin
            mx = 32'd1 << 22;
            csr_write(CSR_PROP_GAIN, $urandom_range(0, 32'd16 << 16));
            csr_write(CSR_INTEGRAL_GAIN, $urandom_range(0, 32'd4 << 16));
            csr_write(CSR_DERIV_GAIN, $urandom_range(0, 32'd1 << 12));
            csr_write(CSR_X_GAIN, $urandom_range(0, mx) - (mx >> 1));
            csr_write(CSR_Y_GAIN, $urandom_range(0, mx) - (mx >> 1));
            csr_write(CSR_TURN_GAIN, $urandom_range(0, mx) - (mx >> 1));
            csr_write(CSR_DIST_PER_TICK, $urandom_range(0, 32'd1 << 24));
         end
      endcase
      csr_write(CSR_IDX_W'(CSR_SPARE + $urandom_range(0, 3) - 3), $urandom);
      csr_write(CSR_ENABLE, (p == 3) ? 32'h0 : 32'({$urandom_range(0, 1) << 1, 1'b1}));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled: request ignored, tick brakes
      speed(16'h7fff, 16'h7fff, 16'h7fff);
      tick(32'd100, 16'd5);
      drain();
      csr_write(CSR_X_GAIN, 32'd32768);
      csr_write(CSR_Y_GAIN, 32'd0);
      csr_write(CSR_TURN_GAIN, 32'd0);
      csr_write(CSR_PROP_GAIN, 32'd3 << 16);
      csr_write(CSR_INTEGRAL_GAIN, 32'd1 << 16);
      csr_write(CSR_DERIV_GAIN, 32'd1 << 10);
      csr_write(CSR_DIST_PER_TICK, 32'd1 << 20);
      csr_write(CSR_SPARE, 32'hffff_ffff);
      csr_write(CSR_ENABLE, 32'd1);
      speed(16'd0, 16'd0, 16'd0);
      tick(32'd120, 16'd10);
      // stop band edges
      speed(16'd656, 16'd0, 16'd0);
      tick(32'd150, 16'd10);
      speed(16'd655, 16'd0, 16'd0);
      tick(32'd160, 16'd10);
      speed(-16'sd656, 16'd0, 16'd0);
      tick(32'd140, 16'd10);
      speed(-16'sd655, 16'd0, 16'd0);
      speed(16'h7fff, 16'h7fff, 16'h7fff);
      tick(32'd200, 16'd0);
      tick(32'd300, 16'hffff);
      tick(32'hffff_fff0, 16'd1);
      tick(32'h0000_0010, 16'd3);
      // sign flip clears the terms
      speed(16'h8000, 16'h8000, 16'h8000);
      tick(32'h8000_0010, 16'd7);
      tick(32'h0000_0010, 16'd7);
      drain();

      for (int p = 0; p < 8; p++) begin
         quiet = (p == 2);
         setup(p);
         enc_pos = $urandom;
         random_items(240);
         drain();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
